>>> design/yuvbs_pkg.sv
`timescale 1ns / 1ps
package yuvbs_pkg;

  localparam int MAX_PLANE_DIM = 4096;
  localparam int MAX_MB_DIM    = 256;
  localparam int NUM_PLANES    = 3;

  localparam int DIM_W      = 13;  // plane sizes and block counts
  localparam int BLK_W      = 7;
  localparam int MB_W       = 9;
  localparam int IDX_W      = 12;
  localparam int FRM_W      = 16;
  localparam int FNUM_W     = 17;
  localparam int OFS_W      = 24;
  localparam int PLANE_W    = 2;
  localparam int ERR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LUMA_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_FRAME   = 3'd7;

  localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_SIZE    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SIZE_CHANGE = 2'd2;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] quotient;
    logic [DIM_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> design/yuvbs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. A start restarts it at once.
module yuvbs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  yuvbs_pkg::div_req_t req,
  output yuvbs_pkg::div_rsp_t rsp
);
  import yuvbs_pkg::*;

  localparam int CNT_W = $clog2(DIM_W + 1);

  logic [DIM_W-1:0] rem_r, rem_nxt;
  logic [DIM_W-1:0] quo_r, quo_nxt;
  logic [DIM_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIM_W:0]   shifted;
  logic [DIM_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DIM_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(DIM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIM_W]) begin
        rem_nxt = diff[DIM_W-1:0];
        quo_nxt = {quo_r[DIM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIM_W-1:0];
        quo_nxt = {quo_r[DIM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> design/yuv_block_scan_address_generator.sv
`timescale 1ns / 1ps
// Block scan address generator for planar Y/U/V frames: each request returns
// the next macroblock (Y, then U, then V, raster order in each plane, frames
// cycled modulo frame_count) with its pixel offset, or an error code with all
// other fields zero. One request is in work at a time; in_stall is high while
// it runs. A request inside a plane, or one that starts a plane at the basic
// block size, passes through S_DECIDE, S_MUL1, S_MUL2 and S_FINISH to a
// loaded result register. A request that starts a plane with a requested
// macroblock size runs up to four divisions on the shared 13-step divider
// for its size checks. After reset and after every register write a pass
// of four divisions works out the block counts of the planes; in_stall
// stays high meanwhile. A finished result waits in the output register
// while the next request is taken.
module yuv_block_scan_address_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_use_basic_size,
  input  logic [yuvbs_pkg::MB_W-1:0]          in_req_mb_width,
  input  logic [yuvbs_pkg::MB_W-1:0]          in_req_mb_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [yuvbs_pkg::PLANE_W-1:0]       out_plane,
  output logic [yuvbs_pkg::IDX_W-1:0]         out_block_row,
  output logic [yuvbs_pkg::IDX_W-1:0]         out_block_col,
  output logic [yuvbs_pkg::MB_W-1:0]          out_mb_width,
  output logic [yuvbs_pkg::MB_W-1:0]          out_mb_height,
  output logic [yuvbs_pkg::FNUM_W-1:0]        out_frame_number,
  output logic [yuvbs_pkg::OFS_W-1:0]         out_pixel_offset,
  output logic                                out_new_frame,
  output logic [yuvbs_pkg::ERR_W-1:0]         out_error,
  input  logic                                cfg_we,
  input  logic [yuvbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [yuvbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import yuvbs_pkg::*;

  localparam int PROD_W = IDX_W + BLK_W;
  localparam int MUL_W  = PROD_W + DIM_W;

  localparam logic [DIM_W-1:0] RST_LUMA_W   = 13'd352;
  localparam logic [DIM_W-1:0] RST_LUMA_H   = 13'd288;
  localparam logic [DIM_W-1:0] RST_CHROMA_W = 13'd176;
  localparam logic [DIM_W-1:0] RST_CHROMA_H = 13'd144;
  localparam logic [BLK_W-1:0] RST_BLK      = 7'd8;
  localparam logic [FRM_W-1:0] RST_FRM_CNT  = 16'd1;

  typedef enum logic [3:0] {
    S_PREP_LC, S_PREP_LR, S_PREP_CC, S_PREP_CR,
    S_IDLE, S_DECIDE,
    S_DIV_MW, S_DIV_MH, S_DIV_PW, S_DIV_PH,
    S_MUL1, S_MUL2, S_FINISH, S_ERR
  } state_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_PLANE_DIM)) ? DIM_W'(MAX_PLANE_DIM) : v;
  endfunction

  // configuration
  logic [DIM_W-1:0] luma_w_r, luma_w_nxt, luma_h_r, luma_h_nxt;
  logic [DIM_W-1:0] chroma_w_r, chroma_w_nxt, chroma_h_r, chroma_h_nxt;
  logic [BLK_W-1:0] blk_w_r, blk_w_nxt, blk_h_r, blk_h_nxt;
  logic [FRM_W-1:0] frame_cnt_r, frame_cnt_nxt, start_frame_r, start_frame_nxt;

  // block counts per plane, from the geometry pass
  logic [DIM_W-1:0] luma_cols_r, luma_cols_nxt, luma_rows_r, luma_rows_nxt;
  logic [DIM_W-1:0] chroma_cols_r, chroma_cols_nxt, chroma_rows_r, chroma_rows_nxt;

  // scan position
  logic [PLANE_W-1:0] cur_plane_r, cur_plane_nxt;
  logic [DIM_W-1:0]   cur_row_r, cur_row_nxt;
  logic [IDX_W-1:0]   cur_col_r, cur_col_nxt;
  logic [FRM_W-1:0]   frame_ctr_r, frame_ctr_nxt;
  logic [MB_W-1:0]    cur_mbw_r, cur_mbw_nxt, cur_mbh_r, cur_mbh_nxt;
  logic [MB_W-1:0]    cur_stc_r, cur_stc_nxt, cur_str_r, cur_str_nxt;

  // request in work
  state_t             state_r, state_nxt;
  logic               issued_r, issued_nxt;
  logic               wk_basic_r, wk_basic_nxt;
  logic [MB_W-1:0]    wk_rw_r, wk_rw_nxt, wk_rh_r, wk_rh_nxt;
  logic [PLANE_W-1:0] wk_plane_r, wk_plane_nxt;
  logic [IDX_W-1:0]   wk_row_r, wk_row_nxt, wk_col_r, wk_col_nxt;
  logic [FRM_W-1:0]   wk_fc_r, wk_fc_nxt;
  logic               wk_newf_r, wk_newf_nxt;
  logic [MB_W-1:0]    wk_mbw_r, wk_mbw_nxt, wk_mbh_r, wk_mbh_nxt;
  logic [MB_W-1:0]    wk_stc_r, wk_stc_nxt, wk_str_r, wk_str_nxt;
  logic [ERR_W-1:0]   wk_err_r, wk_err_nxt;
  logic [PROD_W-1:0]  prod_row_r, prod_row_nxt, prod_col_r, prod_col_nxt;
  logic [OFS_W-1:0]   ofs_r, ofs_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [PLANE_W-1:0] out_plane_r, out_plane_nxt;
  logic [IDX_W-1:0]   out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [MB_W-1:0]    out_mbw_r, out_mbw_nxt, out_mbh_r, out_mbh_nxt;
  logic [FNUM_W-1:0]  out_fnum_r, out_fnum_nxt;
  logic [OFS_W-1:0]   out_ofs_r, out_ofs_nxt;
  logic               out_newf_r, out_newf_nxt;
  logic [ERR_W-1:0]   out_err_r, out_err_nxt;

  // derived values
  logic [BLK_W-1:0]   bw, bh;
  logic [DIM_W-1:0]   lw_s, lh_s, cw_s, ch_s;
  logic               empty_y, empty_c;
  logic [DIM_W-1:0]   cur_rows, cur_cols;
  logic               need_adv;
  logic [PLANE_W-1:0] np;
  logic               pass_y, found;
  logic [FRM_W-1:0]   fc_cnt, fc_inc;
  logic [FNUM_W-1:0]  fc_plus;
  logic [DIM_W-1:0]   wk_pw, wk_ph, wk_cols;
  logic [DIM_W-1:0]   col_sum, col_adv;
  logic               col_wrap;
  logic [MUL_W-1:0]   ofs_full;
  logic               is_div, div_done, can_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  yuvbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign bw   = (blk_w_r == '0) ? BLK_W'(1) : blk_w_r;
  assign bh   = (blk_h_r == '0) ? BLK_W'(1) : blk_h_r;
  assign lw_s = sat_dim(luma_w_r);
  assign lh_s = sat_dim(luma_h_r);
  assign cw_s = sat_dim(chroma_w_r);
  assign ch_s = sat_dim(chroma_h_r);

  assign empty_y  = (luma_cols_r == '0) || (luma_rows_r == '0);
  assign empty_c  = (chroma_cols_r == '0) || (chroma_rows_r == '0);
  assign cur_rows = (cur_plane_r == PLANE_Y) ? luma_rows_r : chroma_rows_r;
  assign cur_cols = (cur_plane_r == PLANE_Y) ? luma_cols_r : chroma_cols_r;
  assign need_adv = (cur_plane_r > PLANE_V) || (cur_row_r >= cur_rows) || (cur_cols == '0);

  // next non-empty plane; passing plane Y means a new frame
  always_comb begin
    np     = cur_plane_r;
    pass_y = 1'b0;
    found  = 1'b0;
    for (int k = 0; k < NUM_PLANES; k++) begin
      if (!found) begin
        np = (np >= PLANE_V) ? PLANE_Y : np + 1'b1;
        if (np == PLANE_Y) begin
          pass_y = 1'b1;
        end
        if (!((np == PLANE_Y) ? empty_y : empty_c)) begin
          found = 1'b1;
        end
      end
    end
  end

  assign fc_cnt  = (frame_cnt_r == '0) ? FRM_W'(1) : frame_cnt_r;
  assign fc_plus = FNUM_W'(frame_ctr_r) + FNUM_W'(1);
  assign fc_inc  = (fc_plus >= FNUM_W'(fc_cnt)) ? '0 : fc_plus[FRM_W-1:0];

  assign wk_pw   = (wk_plane_r == PLANE_Y) ? lw_s : cw_s;
  assign wk_ph   = (wk_plane_r == PLANE_Y) ? lh_s : ch_s;
  assign wk_cols = (wk_plane_r == PLANE_Y) ? luma_cols_r : chroma_cols_r;

  // column step never passes the row end by more than one row
  assign col_sum  = DIM_W'(wk_col_r) + DIM_W'(wk_stc_r);
  assign col_wrap = (col_sum >= wk_cols);
  assign col_adv  = col_wrap ? col_sum - wk_cols : col_sum;

  assign ofs_full = MUL_W'(prod_row_r) * MUL_W'(wk_pw);

  assign is_div = (state_r == S_PREP_LC) || (state_r == S_PREP_LR) ||
                  (state_r == S_PREP_CC) || (state_r == S_PREP_CR) ||
                  (state_r == S_DIV_MW)  || (state_r == S_DIV_MH)  ||
                  (state_r == S_DIV_PW)  || (state_r == S_DIV_PH);
  assign div_done = is_div && issued_r && div_rsp.done;
  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    div_req.start    = is_div && !issued_r;
    div_req.dividend = lw_s;
    div_req.divisor  = DIM_W'(bw);
    case (state_r)
      S_PREP_LC: begin
        div_req.dividend = lw_s;
        div_req.divisor  = DIM_W'(bw);
      end
      S_PREP_LR: begin
        div_req.dividend = lh_s;
        div_req.divisor  = DIM_W'(bh);
      end
      S_PREP_CC: begin
        div_req.dividend = cw_s;
        div_req.divisor  = DIM_W'(bw);
      end
      S_PREP_CR: begin
        div_req.dividend = ch_s;
        div_req.divisor  = DIM_W'(bh);
      end
      S_DIV_MW: begin
        div_req.dividend = DIM_W'(wk_rw_r);
        div_req.divisor  = DIM_W'(bw);
      end
      S_DIV_MH: begin
        div_req.dividend = DIM_W'(wk_rh_r);
        div_req.divisor  = DIM_W'(bh);
      end
      S_DIV_PW: begin
        div_req.dividend = wk_pw;
        div_req.divisor  = DIM_W'(wk_rw_r);
      end
      S_DIV_PH: begin
        div_req.dividend = wk_ph;
        div_req.divisor  = DIM_W'(wk_rh_r);
      end
      default: begin
        div_req.dividend = lw_s;
        div_req.divisor  = DIM_W'(bw);
      end
    endcase
  end

  always_comb begin
    luma_w_nxt      = luma_w_r;
    luma_h_nxt      = luma_h_r;
    chroma_w_nxt    = chroma_w_r;
    chroma_h_nxt    = chroma_h_r;
    blk_w_nxt       = blk_w_r;
    blk_h_nxt       = blk_h_r;
    frame_cnt_nxt   = frame_cnt_r;
    start_frame_nxt = start_frame_r;
    luma_cols_nxt   = luma_cols_r;
    luma_rows_nxt   = luma_rows_r;
    chroma_cols_nxt = chroma_cols_r;
    chroma_rows_nxt = chroma_rows_r;
    cur_plane_nxt   = cur_plane_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    frame_ctr_nxt   = frame_ctr_r;
    cur_mbw_nxt     = cur_mbw_r;
    cur_mbh_nxt     = cur_mbh_r;
    cur_stc_nxt     = cur_stc_r;
    cur_str_nxt     = cur_str_r;
    state_nxt       = state_r;
    issued_nxt      = issued_r;
    wk_basic_nxt    = wk_basic_r;
    wk_rw_nxt       = wk_rw_r;
    wk_rh_nxt       = wk_rh_r;
    wk_plane_nxt    = wk_plane_r;
    wk_row_nxt      = wk_row_r;
    wk_col_nxt      = wk_col_r;
    wk_fc_nxt       = wk_fc_r;
    wk_newf_nxt     = wk_newf_r;
    wk_mbw_nxt      = wk_mbw_r;
    wk_mbh_nxt      = wk_mbh_r;
    wk_stc_nxt      = wk_stc_r;
    wk_str_nxt      = wk_str_r;
    wk_err_nxt      = wk_err_r;
    prod_row_nxt    = prod_row_r;
    prod_col_nxt    = prod_col_r;
    ofs_nxt         = ofs_r;
    out_valid_nxt   = out_valid_r;
    out_plane_nxt   = out_plane_r;
    out_row_nxt     = out_row_r;
    out_col_nxt     = out_col_r;
    out_mbw_nxt     = out_mbw_r;
    out_mbh_nxt     = out_mbh_r;
    out_fnum_nxt    = out_fnum_r;
    out_ofs_nxt     = out_ofs_r;
    out_newf_nxt    = out_newf_r;
    out_err_nxt     = out_err_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (is_div && !issued_r) begin
      issued_nxt = 1'b1;
    end
    if (div_done) begin
      issued_nxt = 1'b0;
    end

    case (state_r)
      S_PREP_LC: begin
        if (div_done) begin
          luma_cols_nxt = div_rsp.quotient;
          state_nxt     = S_PREP_LR;
        end
      end
      S_PREP_LR: begin
        if (div_done) begin
          luma_rows_nxt = div_rsp.quotient;
          state_nxt     = S_PREP_CC;
        end
      end
      S_PREP_CC: begin
        if (div_done) begin
          chroma_cols_nxt = div_rsp.quotient;
          state_nxt       = S_PREP_CR;
        end
      end
      S_PREP_CR: begin
        if (div_done) begin
          chroma_rows_nxt = div_rsp.quotient;
          state_nxt       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          wk_basic_nxt = in_use_basic_size;
          wk_rw_nxt    = in_req_mb_width;
          wk_rh_nxt    = in_req_mb_height;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (need_adv) begin
          wk_plane_nxt = np;
          wk_fc_nxt    = pass_y ? fc_inc : frame_ctr_r;
          wk_newf_nxt  = pass_y;
          wk_row_nxt   = '0;
          wk_col_nxt   = '0;
          if (empty_y && empty_c) begin
            wk_err_nxt = ERR_BAD_SIZE;
            state_nxt  = S_ERR;
          end else if (wk_basic_r) begin
            wk_mbw_nxt = MB_W'(bw);
            wk_mbh_nxt = MB_W'(bh);
            wk_stc_nxt = MB_W'(1);
            wk_str_nxt = MB_W'(1);
            state_nxt  = S_MUL1;
          end else if ((wk_rw_r == '0) || (wk_rh_r == '0) ||
                       (wk_rw_r > MB_W'(MAX_MB_DIM)) || (wk_rh_r > MB_W'(MAX_MB_DIM))) begin
            wk_err_nxt = ERR_BAD_SIZE;
            state_nxt  = S_ERR;
          end else begin
            wk_mbw_nxt = wk_rw_r;
            wk_mbh_nxt = wk_rh_r;
            state_nxt  = S_DIV_MW;
          end
        end else if (!wk_basic_r && ((wk_rw_r != cur_mbw_r) || (wk_rh_r != cur_mbh_r))) begin
          wk_err_nxt = ERR_SIZE_CHANGE;
          state_nxt  = S_ERR;
        end else begin
          // inside a plane the latched size holds, even for a basic-size request
          wk_plane_nxt = cur_plane_r;
          wk_fc_nxt    = frame_ctr_r;
          wk_newf_nxt  = 1'b0;
          wk_row_nxt   = cur_row_r[IDX_W-1:0];
          wk_col_nxt   = cur_col_r;
          wk_mbw_nxt   = cur_mbw_r;
          wk_mbh_nxt   = cur_mbh_r;
          wk_stc_nxt   = cur_stc_r;
          wk_str_nxt   = cur_str_r;
          state_nxt    = S_MUL1;
        end
      end
      S_DIV_MW: begin
        if (div_done) begin
          if (div_rsp.remainder != '0) begin
            wk_err_nxt = ERR_BAD_SIZE;
            state_nxt  = S_ERR;
          end else begin
            wk_stc_nxt = div_rsp.quotient[MB_W-1:0];
            state_nxt  = S_DIV_MH;
          end
        end
      end
      S_DIV_MH: begin
        if (div_done) begin
          if (div_rsp.remainder != '0) begin
            wk_err_nxt = ERR_BAD_SIZE;
            state_nxt  = S_ERR;
          end else begin
            wk_str_nxt = div_rsp.quotient[MB_W-1:0];
            state_nxt  = S_DIV_PW;
          end
        end
      end
      S_DIV_PW: begin
        if (div_done) begin
          if (div_rsp.remainder != '0) begin
            wk_err_nxt = ERR_BAD_SIZE;
            state_nxt  = S_ERR;
          end else begin
            state_nxt = S_DIV_PH;
          end
        end
      end
      S_DIV_PH: begin
        if (div_done) begin
          if (div_rsp.remainder != '0) begin
            wk_err_nxt = ERR_BAD_SIZE;
            state_nxt  = S_ERR;
          end else begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        prod_row_nxt = PROD_W'(wk_row_r) * PROD_W'(bh);
        prod_col_nxt = PROD_W'(wk_col_r) * PROD_W'(bw);
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        ofs_nxt   = ofs_full[OFS_W-1:0] + OFS_W'(prod_col_r);
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_plane_nxt = wk_plane_r;
          out_row_nxt   = wk_row_r;
          out_col_nxt   = wk_col_r;
          out_mbw_nxt   = wk_mbw_r;
          out_mbh_nxt   = wk_mbh_r;
          out_fnum_nxt  = FNUM_W'(wk_fc_r) + FNUM_W'(start_frame_r);
          out_ofs_nxt   = ofs_r;
          out_newf_nxt  = wk_newf_r;
          out_err_nxt   = ERR_OK;
          cur_plane_nxt = wk_plane_r;
          cur_col_nxt   = col_adv[IDX_W-1:0];
          cur_row_nxt   = DIM_W'(wk_row_r) + (col_wrap ? DIM_W'(wk_str_r) : '0);
          frame_ctr_nxt = wk_fc_r;
          cur_mbw_nxt   = wk_mbw_r;
          cur_mbh_nxt   = wk_mbh_r;
          cur_stc_nxt   = wk_stc_r;
          cur_str_nxt   = wk_str_r;
          state_nxt     = S_IDLE;
        end
      end
      S_ERR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_plane_nxt = '0;
          out_row_nxt   = '0;
          out_col_nxt   = '0;
          out_mbw_nxt   = '0;
          out_mbh_nxt   = '0;
          out_fnum_nxt  = '0;
          out_ofs_nxt   = '0;
          out_newf_nxt  = 1'b0;
          out_err_nxt   = wk_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a register write restarts the scan and reruns the geometry pass
    if (cfg_we) begin
      case (cfg_index)
        REG_LUMA_WIDTH:    luma_w_nxt      = cfg_wdata[DIM_W-1:0];
        REG_LUMA_HEIGHT:   luma_h_nxt      = cfg_wdata[DIM_W-1:0];
        REG_CHROMA_WIDTH:  chroma_w_nxt    = cfg_wdata[DIM_W-1:0];
        REG_CHROMA_HEIGHT: chroma_h_nxt    = cfg_wdata[DIM_W-1:0];
        REG_BLOCK_WIDTH:   blk_w_nxt       = cfg_wdata[BLK_W-1:0];
        REG_BLOCK_HEIGHT:  blk_h_nxt       = cfg_wdata[BLK_W-1:0];
        REG_FRAME_COUNT:   frame_cnt_nxt   = cfg_wdata[FRM_W-1:0];
        REG_START_FRAME:   start_frame_nxt = cfg_wdata[FRM_W-1:0];
        default:           start_frame_nxt = start_frame_r;
      endcase
      cur_plane_nxt = PLANE_V;
      cur_row_nxt   = DIM_W'(MAX_PLANE_DIM);
      cur_col_nxt   = '0;
      frame_ctr_nxt = '1;
      state_nxt     = S_PREP_LC;
      issued_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_w_r      <= RST_LUMA_W;
      luma_h_r      <= RST_LUMA_H;
      chroma_w_r    <= RST_CHROMA_W;
      chroma_h_r    <= RST_CHROMA_H;
      blk_w_r       <= RST_BLK;
      blk_h_r       <= RST_BLK;
      frame_cnt_r   <= RST_FRM_CNT;
      start_frame_r <= '0;
      cur_plane_r   <= PLANE_V;
      cur_row_r     <= DIM_W'(MAX_PLANE_DIM);
      cur_col_r     <= '0;
      frame_ctr_r   <= '1;
      state_r       <= S_PREP_LC;
      issued_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      luma_w_r      <= luma_w_nxt;
      luma_h_r      <= luma_h_nxt;
      chroma_w_r    <= chroma_w_nxt;
      chroma_h_r    <= chroma_h_nxt;
      blk_w_r       <= blk_w_nxt;
      blk_h_r       <= blk_h_nxt;
      frame_cnt_r   <= frame_cnt_nxt;
      start_frame_r <= start_frame_nxt;
      cur_plane_r   <= cur_plane_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_col_r     <= cur_col_nxt;
      frame_ctr_r   <= frame_ctr_nxt;
      state_r       <= state_nxt;
      issued_r      <= issued_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    luma_cols_r   <= luma_cols_nxt;
    luma_rows_r   <= luma_rows_nxt;
    chroma_cols_r <= chroma_cols_nxt;
    chroma_rows_r <= chroma_rows_nxt;
    cur_mbw_r     <= cur_mbw_nxt;
    cur_mbh_r     <= cur_mbh_nxt;
    cur_stc_r     <= cur_stc_nxt;
    cur_str_r     <= cur_str_nxt;
    wk_basic_r    <= wk_basic_nxt;
    wk_rw_r       <= wk_rw_nxt;
    wk_rh_r       <= wk_rh_nxt;
    wk_plane_r    <= wk_plane_nxt;
    wk_row_r      <= wk_row_nxt;
    wk_col_r      <= wk_col_nxt;
    wk_fc_r       <= wk_fc_nxt;
    wk_newf_r     <= wk_newf_nxt;
    wk_mbw_r      <= wk_mbw_nxt;
    wk_mbh_r      <= wk_mbh_nxt;
    wk_stc_r      <= wk_stc_nxt;
    wk_str_r      <= wk_str_nxt;
    wk_err_r      <= wk_err_nxt;
    prod_row_r    <= prod_row_nxt;
    prod_col_r    <= prod_col_nxt;
    ofs_r         <= ofs_nxt;
    out_plane_r   <= out_plane_nxt;
    out_row_r     <= out_row_nxt;
    out_col_r     <= out_col_nxt;
    out_mbw_r     <= out_mbw_nxt;
    out_mbh_r     <= out_mbh_nxt;
    out_fnum_r    <= out_fnum_nxt;
    out_ofs_r     <= out_ofs_nxt;
    out_newf_r    <= out_newf_nxt;
    out_err_r     <= out_err_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_plane        = out_plane_r;
  assign out_block_row    = out_row_r;
  assign out_block_col    = out_col_r;
  assign out_mb_width     = out_mbw_r;
  assign out_mb_height    = out_mbh_r;
  assign out_frame_number = out_fnum_r;
  assign out_pixel_offset = out_ofs_r;
  assign out_new_frame    = out_newf_r;
  assign out_error        = out_err_r;

endmodule

>>> design/yuvbs_chk.sv
`timescale 1ns / 1ps
module yuvbs_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_use_basic_size,
  input logic [yuvbs_pkg::MB_W-1:0]       in_req_mb_width,
  input logic [yuvbs_pkg::MB_W-1:0]       in_req_mb_height,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [yuvbs_pkg::PLANE_W-1:0]    out_plane,
  input logic [yuvbs_pkg::IDX_W-1:0]      out_block_row,
  input logic [yuvbs_pkg::IDX_W-1:0]      out_block_col,
  input logic [yuvbs_pkg::MB_W-1:0]       out_mb_width,
  input logic [yuvbs_pkg::MB_W-1:0]       out_mb_height,
  input logic [yuvbs_pkg::FNUM_W-1:0]     out_frame_number,
  input logic [yuvbs_pkg::OFS_W-1:0]      out_pixel_offset,
  input logic                             out_new_frame,
  input logic [yuvbs_pkg::ERR_W-1:0]      out_error,
  input logic                             cfg_we,
  input logic [yuvbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [yuvbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import yuvbs_pkg::*;

  // an error result carries nothing but its code
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != ERR_OK) |->
      (out_plane == '0) && (out_block_row == '0) && (out_block_col == '0) &&
      (out_mb_width == '0) && (out_mb_height == '0) && (out_frame_number == '0) &&
      (out_pixel_offset == '0) && !out_new_frame)
    else $error("error result with nonzero fields");

  // a new frame always starts at the first block of its plane
  a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error == ERR_OK) && out_new_frame |->
      (out_block_row == '0) && (out_block_col == '0))
    else $error("new frame not at block origin");

  a_ok_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error == ERR_OK) |->
      (out_plane <= PLANE_V) && (out_mb_width != '0) && (out_mb_height != '0))
    else $error("bad plane or zero macroblock size in result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_pixel_offset) && $stable(out_error))
    else $error("stalled result changed");

  // geometry pass runs right after reset
  a_reset_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input open right after reset");

endmodule

bind yuv_block_scan_address_generator yuvbs_chk u_yuvbs_chk (.*);
